@@ hdl/jse_pkg.sv @@
package jse_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CTRL_LIMIT = 8'd32;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_ESC,
		KIND_UNI,
		KIND_EMPTY
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       first;
		logic       last;
	} desc_t;

endpackage

@@ hdl/jse_front.sv @@
module jse_front
	import jse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       starts_string,
	input  logic       ends_string,
	input  logic       empty_string,
	output logic       push,
	output desc_t      push_data,
	input  logic       queue_full
);

	logic  valid_s1;
	desc_t desc_s1;
	desc_t desc_c;

	always_comb begin
		desc_c.ch    = data_byte;
		desc_c.first = starts_string;
		desc_c.last  = ends_string;
		desc_c.kind  = KIND_PLAIN;
		if (empty_string) begin
			desc_c.kind  = KIND_EMPTY;
			desc_c.first = 1'b1;
			desc_c.last  = 1'b1;
		end else if (data_byte == CH_QUOTE || data_byte == CH_BSLASH ||
				data_byte == CH_SLASH) begin
			desc_c.kind = KIND_ESC;
		end else if (data_byte == CH_NL) begin
			desc_c.kind = KIND_ESC;
			desc_c.ch   = CH_LOW_N;
		end else if (data_byte == CH_CR) begin
			desc_c.kind = KIND_ESC;
			desc_c.ch   = CH_LOW_R;
		end else if (data_byte < CTRL_LIMIT) begin
			desc_c.kind = KIND_UNI;
		end
	end

	assign in_stall  = valid_s1 && queue_full;
	assign push      = valid_s1 && !queue_full;
	assign push_data = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			desc_s1 <= desc_c;
		end
	end

endmodule

@@ hdl/jse_queue.sv @@
module jse_queue
	import jse_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output desc_t head
);

	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hdl/jse_back.sv @@
module jse_back
	import jse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       nonempty,
	input  desc_t      head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic [2:0] idx_q;
	logic [3:0] body_len;
	logic [3:0] total;
	logic [3:0] last_pos;
	logic [3:0] j;
	logic [7:0] body_byte;
	logic [7:0] cur_byte;
	logic       at_end;
	logic       load;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		hex_digit = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
	endfunction

	always_comb begin
		case (head.kind)
			KIND_PLAIN: body_len = 4'd1;
			KIND_ESC:   body_len = 4'd2;
			KIND_UNI:   body_len = 4'd6;
			KIND_EMPTY: body_len = 4'd0;
			default:    body_len = 4'd0;
		endcase
	end

	assign total    = {3'b000, head.first} + body_len + {3'b000, head.last};
	assign last_pos = total - 4'd1;
	assign at_end   = (idx_q == last_pos[2:0]);
	assign j        = {1'b0, idx_q} - {3'b000, head.first};

	always_comb begin
		body_byte = CH_BSLASH;
		case (head.kind)
			KIND_PLAIN: body_byte = head.ch;
			KIND_ESC: begin
				if (j != 4'd0) begin
					body_byte = head.ch;
				end
			end
			KIND_UNI: begin
				case (j)
					4'd0:    body_byte = CH_BSLASH;
					4'd1:    body_byte = CH_LOW_U;
					4'd2:    body_byte = CH_ZERO;
					4'd3:    body_byte = CH_ZERO;
					4'd4:    body_byte = hex_digit(head.ch[7:4]);
					default: body_byte = hex_digit(head.ch[3:0]);
				endcase
			end
			default: body_byte = CH_QUOTE;
		endcase
	end

	always_comb begin
		if (head.first && idx_q == 3'd0) begin
			cur_byte = CH_QUOTE;
		end else if (j < body_len) begin
			cur_byte = body_byte;
		end else begin
			cur_byte = CH_QUOTE;
		end
	end

	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && nonempty && at_end;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= nonempty;
			if (nonempty) begin
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && nonempty) begin
			out_byte_q <= cur_byte;
			run_last_q <= at_end;
		end
	end

endmodule

@@ hdl/json_string_escaper.sv @@
// An input transfer goes through the front stage register, the queue and the output register
// before its first output byte shows. One output byte per cycle while out_stall is low;
// an input item expands to one byte if plain, up to eight if a control byte with both quotes.
// The rate is set by the single output register, one byte per cycle unless stalled.
// Reset clears the stage valid flag, the queue pointers and count, the output valid flag and the byte index.
module json_string_escaper
	import jse_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       starts_string,
	input  logic       ends_string,
	input  logic       empty_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic  push;
	desc_t push_data;
	logic  queue_full;
	logic  pop;
	logic  nonempty;
	desc_t head;

	jse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.starts_string (starts_string),
		.ends_string   (ends_string),
		.empty_string  (empty_string),
		.push          (push),
		.push_data     (push_data),
		.queue_full    (queue_full)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.nonempty  (nonempty),
		.head      (head)
	);

	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nonempty  (nonempty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

@@ hdl/jse_checker.sv @@
module jse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] data_byte,
	input logic       starts_string,
	input logic       ends_string,
	input logic       empty_string,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_last
);

	// A stalled output byte holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("stalled output changed");

	// An item that is not finished keeps the output busy in the next cycle.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("output gap inside one item");

	// Nothing is shown on the output while reset is held.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	// An idle output only wakes up for an input transfer that has passed the front stage register and the queue.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 3))
		else $error("output byte without input transfer");

endmodule

bind json_string_escaper jse_checker u_chk (.*);

@@ verif/tb_json_string_escaper.sv @@
`timescale 1ns / 100ps

module tb_json_string_escaper;
	import jse_pkg::*;

	localparam logic [7:0] CH_LOW_A = 8'h61;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} json_byte_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       starts_string;
	logic       ends_string;
	logic       empty_string;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	json_byte_t json_q[$];
	int         err_count = 0;
	bit         send_gaps = 1'b1;
	bit         recv_stalls = 1'b1;

	json_string_escaper uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.starts_string(starts_string),
		.ends_string(ends_string),
		.empty_string(empty_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return CH_ZERO + {4'h0, n};
		return CH_LOW_A + {4'h0, n} - 8'd10;
	endfunction

	task automatic predict_json(input logic [7:0] b, input logic s, input logic e,
			input logic em);
		logic [7:0] seq[$];
		json_byte_t jb;
		if (em) begin
			seq.push_back(CH_QUOTE);
			seq.push_back(CH_QUOTE);
		end else begin
			if (s)
				seq.push_back(CH_QUOTE);
			if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH) begin
				seq.push_back(CH_BSLASH);
				seq.push_back(b);
			end else if (b == CH_NL) begin
				seq.push_back(CH_BSLASH);
				seq.push_back(CH_LOW_N);
			end else if (b == CH_CR) begin
				seq.push_back(CH_BSLASH);
				seq.push_back(CH_LOW_R);
			end else if (b < CTRL_LIMIT) begin
				seq.push_back(CH_BSLASH);
				seq.push_back(CH_LOW_U);
				seq.push_back(CH_ZERO);
				seq.push_back(CH_ZERO);
				seq.push_back(hex_char(b[7:4]));
				seq.push_back(hex_char(b[3:0]));
			end else begin
				seq.push_back(b);
			end
			if (e)
				seq.push_back(CH_QUOTE);
		end
		foreach (seq[i]) begin
			jb.ch = seq[i];
			jb.last = (i == seq.size() - 1);
			json_q.push_back(jb);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %02h, want %02h", $realtime, what, got, want);
		err_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_char(input logic [7:0] b, input logic s, input logic e,
			input logic em);
		while (send_gaps && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		starts_string <= s;
		ends_string <= e;
		empty_string <= em;
		predict_json(b, s, e, em);
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] specials[7] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_NL, CH_CR,
			8'h7F, 8'h00};
		case ($urandom_range(9))
			0, 1, 2: return specials[$urandom_range(6)];
			3, 4:    return 8'($urandom_range(31));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_string(input int len);
		for (int i = 0; i < len; i++)
			send_char(pick_char(), i == 0, i == len - 1, 1'b0);
	endtask

	always @(negedge clk)
		out_stall <= recv_stalls && ($urandom_range(99) < 20);

	always @(posedge clk) begin
		json_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (json_q.size() == 0) begin
				report_mismatch("output byte with nothing pending", out_byte, 0);
			end else begin
				want = json_q.pop_front();
				if (out_byte !== want.ch)
					report_mismatch("out_byte", out_byte, want.ch);
				if (run_last !== want.last)
					report_mismatch("run_last", run_last, want.last);
			end
		end
	end

	task automatic test_directed();
		send_char(8'h41, 1'b1, 1'b1, 1'b0);
		send_char(8'h00, 1'b0, 1'b0, 1'b1);
		send_char(8'hFF, 1'b1, 1'b1, 1'b1);
		send_char(8'h61, 1'b1, 1'b0, 1'b0);
		send_char(CH_QUOTE, 1'b0, 1'b0, 1'b0);
		send_char(8'h62, 1'b0, 1'b1, 1'b0);
		send_char(CH_BSLASH, 1'b1, 1'b1, 1'b0);
		send_char(CH_SLASH, 1'b0, 1'b0, 1'b0);
		send_char(CH_NL, 1'b1, 1'b0, 1'b0);
		send_char(CH_CR, 1'b0, 1'b1, 1'b0);
		send_char(8'h00, 1'b0, 1'b0, 1'b0);
		send_char(8'h1F, 1'b0, 1'b0, 1'b0);
		send_char(8'h01, 1'b1, 1'b1, 1'b0);
		send_char(8'h1A, 1'b0, 1'b0, 1'b0);
		send_char(8'h7F, 1'b0, 1'b0, 1'b0);
		send_char(8'h80, 1'b0, 1'b0, 1'b0);
		send_char(8'hFF, 1'b0, 1'b0, 1'b0);
		send_char(8'h20, 1'b0, 1'b0, 1'b0);
		// A start with no end before it, and an end with no start.
		send_char(8'h41, 1'b1, 1'b0, 1'b0);
		send_char(8'h42, 1'b1, 1'b0, 1'b0);
		send_char(8'h43, 1'b0, 1'b1, 1'b0);
		send_char(8'h44, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_back_to_back();
		int sent;
		sent = 0;
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		while (sent < 40) begin
			send_string(4);
			sent += 4;
		end
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
	endtask

	task automatic test_strings();
		int sent;
		int len;
		sent = 0;
		while (sent < 250) begin
			if ($urandom_range(9) == 0) begin
				send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b1);
				sent++;
			end else begin
				len = $urandom_range(1, 8);
				send_string(len);
				sent += len;
			end
		end
	endtask

	task automatic test_noise();
		for (int i = 0; i < 40; i++)
			send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)), $urandom_range(7) == 0);
	endtask

	task automatic finish_run();
		in_valid <= 1'b0;
		while (json_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		starts_string = 1'b0;
		ends_string = 1'b0;
		empty_string = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_back_to_back();
		test_strings();
		test_noise();
		finish_run();
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
